FILE: rtl/core/slr_pkg.sv
// Shared constants and types for the scrollback line ring.
// No dependencies; imported by the ring top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

    // Defaults for the top-level size parameters
    localparam int DEF_LINE_CAP   = 256;
    localparam int DEF_LINE_WIDTH = 128;

    // Window row register
    localparam int          ROWS_W     = 10;
    localparam logic [9:0]  ROWS_RESET = 10'd24;

    localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;

    // Item kinds, carried on s_tuser
    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_SCROLL = 3'd1,
        OP_READ   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_SHIFT  = 3'd4
    } opcode_t;

    // Input tdata layout
    localparam int IN_TDATA_W  = 56;
    localparam int IN_BYTE_LSB = 0;
    localparam int IN_DLT_LSB  = 8;
    localparam int IN_ADD_LSB  = 24;
    localparam int IN_IDX_LSB  = 40;
    localparam int IN_COL_LSB  = 48;

    // Result tdata layout
    localparam int OUT_TDATA_W = 64;
    localparam int LCNT_LSB    = 0;
    localparam int LCNT_W      = 9;
    localparam int FVIS_LSB    = 9;
    localparam int FVIS_W      = 8;
    localparam int SOFF_LSB    = 17;
    localparam int RCHR_LSB    = 33;
    localparam int IVLD_BIT    = 41;
    localparam int LWR_LSB     = 42;

endpackage

`default_nettype wire

FILE: rtl/core/slr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module slr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/scrollback_line_ring.sv
// Scrollback line ring: text lines kept in a ring of slots, with scroll state.
// Depends on slr_pkg and slr_ram (character store and line length store).
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata (fields), s_tlast (end_of_text),
//                                      s_tuser (opcode)
//  m_        out  m_tvalid/m_tready    m_tdata (status and read fields)
//  cfg_      in   cfg_valid/cfg_ready  cfg_data (visible_rows)
//
//  Every item passes through accept (control state update), memory access
//  (store write or registered read of both RAMs) and reply (status into the
//  output register). A new item is taken only after the previous reply.
//  Reset (aresetn low, synchronous) resets all control state; the RAMs are
//  not cleared, only written entries are ever read back. A stalled result
//  sits in the output register; the next item is still accepted meanwhile,
//  and its reply waits until that register frees up.

module scrollback_line_ring import slr_pkg::*; #(
    parameter int LINE_CAP   = DEF_LINE_CAP,
    parameter int LINE_WIDTH = DEF_LINE_WIDTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input items
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [7:0] data_byte, [23:8] scroll_delta, [39:24] added_lines,
    // [47:40] line_index, [54:48] column_index, [55] zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tlast,     // end_of_text
    input  wire logic [2:0]             s_tuser,     // [2:0] opcode
    // result items
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [8:0] line_count, [16:9] first_visible, [32:17] scroll_offset,
    // [40:33] read_char, [41] index_valid, [57:42] lines_written, [63:58] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // configuration: visible_rows
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [ROWS_W-1:0]      cfg_data
);

    // Widths
    localparam int SW    = $clog2(LINE_CAP);              // slot index
    localparam int HW    = $clog2(LINE_CAP + 1);          // held line count
    localparam int LW    = $clog2(LINE_WIDTH);            // line length 0..W-1
    localparam int OFFW  = (LW > 7) ? LW : 7;             // offset within a line
    localparam int SDEP  = LINE_CAP * LINE_WIDTH;
    localparam int AW    = $clog2(SDEP);                  // store address
    localparam int PW    = ((SW > 8) ? SW : 8) + 1;       // slot + line index sum
    localparam int CW    = ((HW > 16) ? HW : 16) + 2;     // scroll arithmetic

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ACCESS = 3'b010,
        ST_REPLY  = 3'b100
    } state_t;

    // Input fields
    opcode_t            op;
    logic [7:0]         in_byte;
    logic signed [15:0] in_delta;
    logic [15:0]        in_added;
    logic [7:0]         in_idx;
    logic [6:0]         in_col;

    assign op       = opcode_t'(s_tuser);
    assign in_byte  = s_tdata[IN_BYTE_LSB +: 8];
    assign in_delta = $signed(s_tdata[IN_DLT_LSB +: 16]);
    assign in_added = s_tdata[IN_ADD_LSB +: 16];
    assign in_idx   = s_tdata[IN_IDX_LSB +: 8];
    assign in_col   = s_tdata[IN_COL_LSB +: 7];

    // Control state
    state_t             state_reg, state_next;
    logic [SW-1:0]      oldest_reg, oldest_next;
    logic [HW-1:0]      held_reg, held_next;
    logic [15:0]        scroll_reg, scroll_next;
    logic               at_start_reg, at_start_next;
    logic [SW-1:0]      cur_slot_reg, cur_slot_next;
    logic [LW-1:0]      cur_len_reg, cur_len_next;   // length of the current line
    logic [15:0]        cnt_reg, cnt_next;
    logic [ROWS_W-1:0]  rows_reg;

    // Access stage
    logic [SW-1:0]      acc_slot_reg, acc_slot_next;
    logic [OFFW-1:0]    acc_off_reg, acc_off_next;
    logic [LW-1:0]      acc_len_reg, acc_len_next;
    logic [7:0]         acc_byte_reg, acc_byte_next;
    logic               acc_store_we_reg, acc_store_we_next;
    logic               acc_len_we_reg, acc_len_we_next;
    logic               acc_rd_reg, acc_rd_next;

    // Reply stage
    logic               rep_valid_reg, rep_valid_next;   // read of a held line
    logic [15:0]        rep_written_reg, rep_written_next;

    // Output register
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic accept;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Fresh line slot: the oldest one when full, else the one after the newest
    logic          full;
    logic [SW-1:0] oldest_inc;
    logic [SW:0]   slot_sum;
    logic [SW-1:0] slot_fresh;

    assign full       = (held_reg == HW'(LINE_CAP));
    assign oldest_inc = (oldest_reg == SW'(LINE_CAP - 1)) ? '0 : oldest_reg + 1'b1;
    assign slot_sum   = (SW+1)'(oldest_reg) + (SW+1)'(held_reg);
    assign slot_fresh = full ? oldest_reg :
                        (slot_sum >= (SW+1)'(LINE_CAP)) ?
                            SW'(slot_sum - (SW+1)'(LINE_CAP)) : SW'(slot_sum);

    logic [LW-1:0] len_base;
    logic          len_room;
    logic [15:0]   cnt_inc;

    assign len_base = at_start_reg ? '0 : cur_len_reg;
    assign len_room = (len_base < LW'(LINE_WIDTH - 1));
    assign cnt_inc  = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;

    // Logical line to physical slot for reads
    logic [PW-1:0] phys_sum;
    logic [SW-1:0] phys_slot;
    logic          idx_ok;

    assign phys_sum  = PW'(oldest_reg) + PW'(in_idx);
    assign phys_slot = (phys_sum >= PW'(LINE_CAP)) ?
                       SW'(phys_sum - PW'(LINE_CAP)) : SW'(phys_sum);
    assign idx_ok    = (CW'(in_idx) < CW'(held_reg));

    // Scroll range upper bound: max(held - rows, 0)
    logic [CW-1:0] held_w, rows_w, mx_w;
    logic          held_gt_rows;

    assign held_w       = CW'(held_reg);
    assign rows_w       = CW'(rows_reg);
    assign held_gt_rows = (held_w > rows_w);
    assign mx_w         = held_gt_rows ? held_w - rows_w : '0;

    // Scroll by delta, clamped to [0, min(mx, 65535)]
    logic signed [CW-1:0] sum_s;
    logic [15:0]          scroll_clamp;

    assign sum_s = $signed(CW'(scroll_reg)) + CW'(in_delta);

    always_comb begin
        priority if (sum_s > $signed(mx_w)) begin
            scroll_clamp = (mx_w > CW'(16'hFFFF)) ? 16'hFFFF : 16'(mx_w);
        end else if (sum_s < 0) begin
            scroll_clamp = '0;
        end else if (sum_s > $signed(CW'(16'hFFFF))) begin
            scroll_clamp = 16'hFFFF;
        end else begin
            scroll_clamp = 16'(sum_s);
        end
    end

    // Shift after append, saturating
    logic [16:0] shift_sum;
    logic [15:0] shift_sat;

    assign shift_sum = 17'(scroll_reg) + 17'(in_added);
    assign shift_sat = shift_sum[16] ? 16'hFFFF : shift_sum[15:0];

    // Top visible line from the held count and the clamped offset
    logic [CW-1:0] off_w, first_w, last_w;
    logic [7:0]    first_vis;

    assign off_w   = (CW'(scroll_reg) < mx_w) ? CW'(scroll_reg) : mx_w;
    assign first_w = mx_w - off_w;
    assign last_w  = held_w - 1'b1;
    assign first_vis = (held_reg == '0 || !held_gt_rows) ? 8'd0 :
                       (first_w > last_w) ? 8'(last_w) : 8'(first_w);

    // Memories
    logic [AW-1:0]  store_addr;
    logic [7:0]     store_rdata;
    logic [LW-1:0]  len_rdata;
    logic           mem_rd;

    assign store_addr = AW'(acc_slot_reg) * AW'(LINE_WIDTH) + AW'(acc_off_reg);
    assign mem_rd     = (state_reg == ST_ACCESS) && acc_rd_reg;

    slr_ram #(
        .WIDTH (8),
        .DEPTH (SDEP)
    ) u_store (
        .aclk  (aclk),
        .we    ((state_reg == ST_ACCESS) && acc_store_we_reg),
        .waddr (store_addr),
        .wdata (acc_byte_reg),
        .re    (mem_rd),
        .raddr (store_addr),
        .rdata (store_rdata)
    );

    slr_ram #(
        .WIDTH (LW),
        .DEPTH (LINE_CAP)
    ) u_len (
        .aclk  (aclk),
        .we    ((state_reg == ST_ACCESS) && acc_len_we_reg),
        .waddr (acc_slot_reg),
        .wdata (acc_len_reg),
        .re    (mem_rd),
        .raddr (acc_slot_reg),
        .rdata (len_rdata)
    );

    // Reply fields
    logic [7:0] read_char;
    assign read_char = (rep_valid_reg && (OFFW'(len_rdata) > acc_off_reg)) ?
                       store_rdata : 8'd0;

    // Next state
    always_comb begin
        state_next        = state_reg;
        oldest_next       = oldest_reg;
        held_next         = held_reg;
        scroll_next       = scroll_reg;
        at_start_next     = at_start_reg;
        cur_slot_next     = cur_slot_reg;
        cur_len_next      = cur_len_reg;
        cnt_next          = cnt_reg;
        acc_slot_next     = acc_slot_reg;
        acc_off_next      = acc_off_reg;
        acc_len_next      = acc_len_reg;
        acc_byte_next     = acc_byte_reg;
        acc_store_we_next = acc_store_we_reg;
        acc_len_we_next   = acc_len_we_reg;
        acc_rd_next       = acc_rd_reg;
        rep_valid_next    = rep_valid_reg;
        rep_written_next  = rep_written_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_data_next       = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next        = ST_ACCESS;
                    acc_store_we_next = 1'b0;
                    acc_len_we_next   = 1'b0;
                    acc_rd_next       = 1'b0;
                    rep_valid_next    = 1'b0;
                    rep_written_next  = cnt_reg;
                    acc_byte_next     = in_byte;
                    unique case (op)
                        OP_PUSH: begin
                            acc_slot_next = at_start_reg ? slot_fresh : cur_slot_reg;
                            cur_slot_next = acc_slot_next;
                            acc_off_next  = OFFW'(len_base);
                            cur_len_next  = len_base;
                            if (at_start_reg) begin
                                held_next       = full ? held_reg : held_reg + 1'b1;
                                oldest_next     = full ? oldest_inc : oldest_reg;
                                acc_len_we_next = 1'b1;
                                acc_len_next    = '0;
                                rep_written_next = cnt_inc;
                            end
                            if (in_byte != NEWLINE_BYTE && len_room) begin
                                acc_store_we_next = 1'b1;
                                acc_len_we_next   = 1'b1;
                                acc_len_next      = len_base + 1'b1;
                                cur_len_next      = len_base + 1'b1;
                            end
                            at_start_next = (in_byte == NEWLINE_BYTE) || s_tlast;
                            cnt_next      = s_tlast ? 16'd0 : rep_written_next;
                        end
                        OP_SCROLL: begin
                            scroll_next = scroll_clamp;
                        end
                        OP_READ: begin
                            acc_slot_next  = phys_slot;
                            acc_off_next   = OFFW'(in_col);
                            acc_rd_next    = idx_ok;
                            rep_valid_next = idx_ok;
                        end
                        OP_CLEAR: begin
                            oldest_next      = '0;
                            held_next        = '0;
                            scroll_next      = '0;
                            at_start_next    = 1'b1;
                            cnt_next         = '0;
                            rep_written_next = '0;
                        end
                        OP_SHIFT: begin
                            if (scroll_reg != 16'd0) begin
                                scroll_next = shift_sat;
                            end
                        end
                        default: begin
                            // unused kinds only report status
                        end
                    endcase
                end
            end
            ST_ACCESS: begin
                state_next = ST_REPLY;
            end
            ST_REPLY: begin
                if (!m_valid_reg || m_tready) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, rep_written_reg, rep_valid_reg, read_char,
                                    scroll_reg, first_vis, LCNT_W'(held_reg)};
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            oldest_reg   <= '0;
            held_reg     <= '0;
            scroll_reg   <= '0;
            at_start_reg <= 1'b1;
            cur_slot_reg <= '0;
            cur_len_reg  <= '0;
            cnt_reg      <= '0;
            rows_reg     <= ROWS_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            oldest_reg   <= oldest_next;
            held_reg     <= held_next;
            scroll_reg   <= scroll_next;
            at_start_reg <= at_start_next;
            cur_slot_reg <= cur_slot_next;
            cur_len_reg  <= cur_len_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                rows_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        acc_slot_reg     <= acc_slot_next;
        acc_off_reg      <= acc_off_next;
        acc_len_reg      <= acc_len_next;
        acc_byte_reg     <= acc_byte_next;
        acc_store_we_reg <= acc_store_we_next;
        acc_len_we_reg   <= acc_len_we_next;
        acc_rd_reg       <= acc_rd_next;
        rep_valid_reg    <= rep_valid_next;
        rep_written_reg  <= rep_written_next;
        m_data_reg       <= m_data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/slr_checker.sv
// Port-level checks for the scrollback line ring, bound to its top level.
// Depends on slr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slr_port_checks import slr_pkg::*; #(
    parameter int LINE_CAP = DEF_LINE_CAP
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [LCNT_W-1:0] lc;
    logic [FVIS_W-1:0] fv;
    logic [7:0]        rc;
    logic              iv;

    assign lc = m_tdata[LCNT_LSB +: LCNT_W];
    assign fv = m_tdata[FVIS_LSB +: FVIS_W];
    assign rc = m_tdata[RCHR_LSB +: 8];
    assign iv = m_tdata[IVLD_BIT];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous one in flight");

    // a nonzero character only comes from a valid read
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (rc != 8'd0) |-> iv)
        else $error("read_char set without index_valid");

    // top visible line lies inside the held lines
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (LINE_CAP <= 256) |->
            (lc == '0 && fv == '0) || (lc != '0 && LCNT_W'(fv) < lc))
        else $error("first_visible out of range");

    // held count never exceeds the ring size
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (LINE_CAP <= 256) |-> (32'(lc) <= LINE_CAP))
        else $error("line_count above capacity");

endmodule

bind scrollback_line_ring slr_port_checks #(
    .LINE_CAP (LINE_CAP)
) u_slr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
